// ===== rtl/msp_pkg.sv =====
// Package for the midpoint spin transform: word formats, internal widths and
// the packed word types passed between the pipeline sections. No dependencies.
package msp_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 24;

  localparam int unsigned HALF_W = WORD_BITS - 1;
  localparam int unsigned EA_W   = WORD_BITS + HALF_W;
  localparam int unsigned EAR_W  = EA_W - FRAC_BITS;
  localparam int unsigned A2_W   = EAR_W + 1;
  localparam int unsigned AA_W   = 2 * HALF_W;
  localparam int unsigned M_W    = AA_W - FRAC_BITS;
  localparam int unsigned DEN_W  = M_W;
  localparam int unsigned MP_W   = A2_W + M_W;
  localparam int unsigned MR_W   = MP_W - FRAC_BITS;
  localparam int unsigned NUM_W  = MR_W + 2;
  localparam int unsigned MAG_W  = NUM_W;
  localparam int unsigned Q_W    = WORD_BITS + 1;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] spin_x;
    logic signed [WORD_BITS-1:0] spin_y;
    logic signed [WORD_BITS-1:0] spin_z;
    logic signed [WORD_BITS-1:0] force_x;
    logic signed [WORD_BITS-1:0] force_y;
    logic signed [WORD_BITS-1:0] force_z;
  } msp_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_x;
    logic signed [WORD_BITS-1:0] result_y;
    logic signed [WORD_BITS-1:0] result_z;
    logic                        saturated;
  } msp_out_t;

  typedef struct packed {
    logic [2:0][A2_W-1:0]     a2;
    logic [2:0][2:0][M_W-1:0] m;
    logic [DEN_W-1:0]         den;
  } msp_frt_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [DEN_W-1:0]      den;
  } msp_mac_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] quo;
    logic [2:0]          ovf;
    logic [2:0]          neg;
  } msp_quo_t;

endpackage

// ===== rtl/msp_front.sv =====
// Front section: halve the force, form spin x A and A A^T products, then the
// predictor a2, the midpoint matrix and the determinant. Two stages. Uses msp_pkg.
module msp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msp_pkg::msp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msp_pkg::msp_frt_t  out_data_o
);

  localparam int unsigned W     = msp_pkg::WORD_BITS;
  localparam int unsigned F     = msp_pkg::FRAC_BITS;
  localparam int unsigned HW    = msp_pkg::HALF_W;
  localparam int unsigned EA_W  = msp_pkg::EA_W;
  localparam int unsigned EAR_W = msp_pkg::EAR_W;
  localparam int unsigned A2_W  = msp_pkg::A2_W;
  localparam int unsigned AA_W  = msp_pkg::AA_W;
  localparam int unsigned M_W   = msp_pkg::M_W;

  localparam logic [EA_W-1:0] EA_HALF = EA_W'(1) << (F - 1);
  localparam logic [AA_W-1:0] AA_HALF = AA_W'(1) << (F - 1);
  localparam logic [M_W-1:0]  M_ONE   = M_W'(1) << F;

  function automatic logic [EAR_W-1:0] rnd_ea(logic [EA_W-1:0] p);
    logic [EA_W-1:0] s;
    s = p + EA_HALF - EA_W'(p[EA_W-1]);
    return s[EA_W-1:F];
  endfunction

  function automatic logic [M_W-1:0] rnd_aa(logic [AA_W-1:0] p);
    logic [AA_W-1:0] s;
    s = p + AA_HALF - AA_W'(p[AA_W-1]);
    return s[AA_W-1:F];
  endfunction

  logic v1_q, v2_q, en1, en2;

  logic signed [W-1:0]    e_d   [3];
  logic signed [W-1:0]    e_q   [3];
  logic signed [HW-1:0]   a_d   [3];
  logic signed [HW-1:0]   a_q   [3];
  logic signed [EA_W-1:0] pea_d [6];
  logic signed [EA_W-1:0] pea_q [6];
  logic signed [AA_W-1:0] paa_d [6];
  logic signed [AA_W-1:0] paa_q [6];

  logic signed [EAR_W-1:0] rea [6];
  logic signed [M_W-1:0]   raa [6];
  logic signed [A2_W-1:0]  c   [3];
  msp_pkg::msp_frt_t       frt_d, frt_q;

  assign en2        = ~v2_q | out_ready_i;
  assign en1        = ~v1_q | en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_comb begin
    e_d[0] = in_data_i.spin_x;
    e_d[1] = in_data_i.spin_y;
    e_d[2] = in_data_i.spin_z;
    a_d[0] = in_data_i.force_x[W-1:1];
    a_d[1] = in_data_i.force_y[W-1:1];
    a_d[2] = in_data_i.force_z[W-1:1];
    pea_d[0] = e_d[1] * a_d[2];
    pea_d[1] = e_d[2] * a_d[1];
    pea_d[2] = e_d[2] * a_d[0];
    pea_d[3] = e_d[0] * a_d[2];
    pea_d[4] = e_d[0] * a_d[1];
    pea_d[5] = e_d[1] * a_d[0];
    paa_d[0] = a_d[0] * a_d[0];
    paa_d[1] = a_d[1] * a_d[1];
    paa_d[2] = a_d[2] * a_d[2];
    paa_d[3] = a_d[0] * a_d[1];
    paa_d[4] = a_d[0] * a_d[2];
    paa_d[5] = a_d[1] * a_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      e_q   <= e_d;
      a_q   <= a_d;
      pea_q <= pea_d;
      paa_q <= paa_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rea[i] = rnd_ea(pea_q[i]);
      raa[i] = rnd_aa(paa_q[i]);
    end
    c[0] = A2_W'(rea[0]) - A2_W'(rea[1]);
    c[1] = A2_W'(rea[2]) - A2_W'(rea[3]);
    c[2] = A2_W'(rea[4]) - A2_W'(rea[5]);
    for (int i = 0; i < 3; i++) begin
      frt_d.a2[i] = A2_W'(e_q[i]) - c[i];
    end
    frt_d.m[0][0] = raa[0] + M_ONE;
    frt_d.m[0][1] = raa[3] - M_W'(a_q[2]);
    frt_d.m[0][2] = raa[4] + M_W'(a_q[1]);
    frt_d.m[1][0] = raa[3] + M_W'(a_q[2]);
    frt_d.m[1][1] = raa[1] + M_ONE;
    frt_d.m[1][2] = raa[5] - M_W'(a_q[0]);
    frt_d.m[2][0] = raa[4] - M_W'(a_q[1]);
    frt_d.m[2][1] = raa[5] + M_W'(a_q[0]);
    frt_d.m[2][2] = raa[2] + M_ONE;
    frt_d.den     = M_ONE + raa[0] + raa[1] + raa[2];
  end

  always_ff @(posedge clk_i) begin
    if (en2) frt_q <= frt_d;
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = frt_q;

endmodule

// ===== rtl/msp_mac.sv =====
// Matrix-vector section: split products of a2 and the midpoint matrix into
// partial products, recombine and round, then sum rows to sign and magnitude.
// Three stages. Uses msp_pkg.
module msp_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msp_pkg::msp_frt_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msp_pkg::msp_mac_t  out_data_o
);

  localparam int unsigned F     = msp_pkg::FRAC_BITS;
  localparam int unsigned A2_W  = msp_pkg::A2_W;
  localparam int unsigned M_W   = msp_pkg::M_W;
  localparam int unsigned DEN_W = msp_pkg::DEN_W;
  localparam int unsigned MP_W  = msp_pkg::MP_W;
  localparam int unsigned MR_W  = msp_pkg::MR_W;
  localparam int unsigned NUM_W = msp_pkg::NUM_W;
  localparam int unsigned AL    = A2_W / 2;
  localparam int unsigned AH    = A2_W - AL;
  localparam int unsigned ML    = M_W / 2;
  localparam int unsigned MH    = M_W - ML;
  localparam int unsigned LL_W  = AL + ML + 2;
  localparam int unsigned LH_W  = AL + 1 + MH;
  localparam int unsigned HL_W  = AH + ML + 1;
  localparam int unsigned HH_W  = AH + MH;

  localparam logic [MP_W-1:0] MP_HALF = MP_W'(1) << (F - 1);

  function automatic logic [MR_W-1:0] rnd_mp(logic [MP_W-1:0] p);
    logic [MP_W-1:0] s;
    s = p + MP_HALF - MP_W'(p[MP_W-1]);
    return s[MP_W-1:F];
  endfunction

  logic v1_q, v2_q, v3_q, en1, en2, en3;

  logic signed [LL_W-1:0] ll_d [3][3];
  logic signed [LL_W-1:0] ll_q [3][3];
  logic signed [LH_W-1:0] lh_d [3][3];
  logic signed [LH_W-1:0] lh_q [3][3];
  logic signed [HL_W-1:0] hl_d [3][3];
  logic signed [HL_W-1:0] hl_q [3][3];
  logic signed [HH_W-1:0] hh_d [3][3];
  logic signed [HH_W-1:0] hh_q [3][3];
  logic [DEN_W-1:0]       den1_q, den2_q;

  logic signed [MR_W-1:0] prod_d [3][3];
  logic signed [MR_W-1:0] prod_q [3][3];

  logic signed [NUM_W-1:0] num [3];
  msp_pkg::msp_mac_t       mac_d, mac_q;

  assign en3        = ~v3_q | out_ready_i;
  assign en2        = ~v2_q | en3;
  assign en1        = ~v1_q | en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ll_d[i][j] = $signed({1'b0, in_data_i.a2[j][AL-1:0]})
                   * $signed({1'b0, in_data_i.m[i][j][ML-1:0]});
        lh_d[i][j] = $signed({1'b0, in_data_i.a2[j][AL-1:0]})
                   * $signed(in_data_i.m[i][j][M_W-1:ML]);
        hl_d[i][j] = $signed(in_data_i.a2[j][A2_W-1:AL])
                   * $signed({1'b0, in_data_i.m[i][j][ML-1:0]});
        hh_d[i][j] = $signed(in_data_i.a2[j][A2_W-1:AL])
                   * $signed(in_data_i.m[i][j][M_W-1:ML]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      hh_q   <= hh_d;
      den1_q <= in_data_i.den;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = rnd_mp((MP_W'(hh_q[i][j]) <<< (AL + ML))
                            + (MP_W'(lh_q[i][j]) <<< ML)
                            + (MP_W'(hl_q[i][j]) <<< AL)
                            + MP_W'(ll_q[i][j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q <= prod_d;
      den2_q <= den1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'(prod_q[i][0]) + NUM_W'(prod_q[i][1]) + NUM_W'(prod_q[i][2]);
      mac_d.neg[i] = num[i][NUM_W-1];
      mac_d.mag[i] = num[i][NUM_W-1] ? -num[i] : num[i];
    end
    mac_d.den = den2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) mac_q <= mac_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = mac_q;

endmodule

// ===== rtl/msp_div.sv =====
// Pipelined restoring divider: three lanes share one determinant, three
// quotient bits per stage, with an up-front range check. Uses msp_pkg.
module msp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msp_pkg::msp_mac_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msp_pkg::msp_quo_t  out_data_o
);

  localparam int unsigned F     = msp_pkg::FRAC_BITS;
  localparam int unsigned DEN_W = msp_pkg::DEN_W;
  localparam int unsigned MAG_W = msp_pkg::MAG_W;
  localparam int unsigned Q_W   = msp_pkg::Q_W;
  localparam int unsigned RW_W  = DEN_W + Q_W;
  localparam int unsigned DVD_W = MAG_W + F + 1;
  localparam int unsigned HI_W  = DVD_W - Q_W;
  localparam int unsigned STEP  = 3;
  localparam int unsigned NSTG  = (Q_W + STEP - 1) / STEP;

  function automatic logic [RW_W-1:0] div_step(logic [RW_W-1:0] rw, logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    logic [DEN_W:0] df;
    t  = {rw[RW_W-1:Q_W], rw[Q_W-1]};
    df = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {df[DEN_W-1:0], rw[Q_W-2:0], 1'b1};
    end else begin
      return {t[DEN_W-1:0], rw[Q_W-2:0], 1'b0};
    end
  endfunction

  logic [NSTG:0]     v_q;
  logic [NSTG+1:0]   en;
  logic [RW_W-1:0]   rw_d  [NSTG+1][3];
  logic [RW_W-1:0]   rw_q  [NSTG+1][3];
  logic [DEN_W-1:0]  den_d [NSTG+1];
  logic [DEN_W-1:0]  den_q [NSTG+1];
  logic [2:0]        ovf_d [NSTG+1];
  logic [2:0]        ovf_q [NSTG+1];
  logic [2:0]        neg_d [NSTG+1];
  logic [2:0]        neg_q [NSTG+1];

  always_comb begin
    en[NSTG+1] = out_ready_i;
    for (int k = NSTG; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    logic [DVD_W-1:0] dvd;
    logic [HI_W-1:0]  hi;
    for (int l = 0; l < 3; l++) begin
      dvd = DVD_W'({in_data_i.mag[l], {F{1'b0}}}) + DVD_W'(in_data_i.den >> 1);
      hi  = dvd[DVD_W-1:Q_W];
      ovf_d[0][l] = hi >= HI_W'(in_data_i.den);
      rw_d[0][l]  = {hi[DEN_W-1:0], dvd[Q_W-1:0]};
    end
    neg_d[0] = in_data_i.neg;
    den_d[0] = in_data_i.den;
    for (int k = 1; k <= NSTG; k++) begin
      for (int l = 0; l < 3; l++) begin
        rw_d[k][l] = rw_q[k-1][l];
        for (int s = 0; s < STEP; s++) begin
          if ((k - 1) * STEP + s < Q_W) rw_d[k][l] = div_step(rw_d[k][l], den_q[k-1]);
        end
      end
      ovf_d[k] = ovf_q[k-1];
      neg_d[k] = neg_q[k-1];
      den_d[k] = den_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NSTG; k++) begin
      if (en[k]) begin
        rw_q[k]  <= rw_d[k];
        ovf_q[k] <= ovf_d[k];
        neg_q[k] <= neg_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_data_o.quo[l] = rw_q[NSTG][l][Q_W-1:0];
    end
    out_data_o.ovf = ovf_q[NSTG];
    out_data_o.neg = neg_q[NSTG];
  end

  assign out_valid_o = v_q[NSTG];

endmodule

// ===== rtl/sib_midpoint_spin_transform_unit.sv =====
// Semi-implicit midpoint spin transform, top level. Takes one spin and force
// word per cycle and returns one transformed, saturated vector word per input.
// Registered sections, in order: the front products, the matrix-vector
// products, the divider (range check, then 3 quotient bits per stage) and the
// output register. Sustained rate is one word per cycle; each stage holds
// only when its successor is full, so a blocked output fills bubbles before
// input ready drops. Out-of-range results clamp and raise the saturated flag.
// Depends on msp_pkg, msp_front, msp_mac and msp_div.
module sib_midpoint_spin_transform_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msp_pkg::msp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msp_pkg::msp_out_t  out_data_o
);

  localparam int unsigned W   = msp_pkg::WORD_BITS;
  localparam int unsigned Q_W = msp_pkg::Q_W;

  localparam logic [W-1:0] W_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] W_MIN = {1'b1, {(W - 1){1'b0}}};

  logic               frt_valid, frt_ready;
  msp_pkg::msp_frt_t  frt_data;
  logic               mac_valid, mac_ready;
  msp_pkg::msp_mac_t  mac_data;
  logic               div_valid, div_ready;
  msp_pkg::msp_quo_t  div_data;

  logic               out_valid_q;
  msp_pkg::msp_out_t  out_d, out_q;
  logic [W-1:0]       res [3];
  logic [2:0]         lane_sat;

  msp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (frt_valid),
    .out_ready_i (frt_ready),
    .out_data_o  (frt_data)
  );

  msp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frt_valid),
    .in_ready_o  (frt_ready),
    .in_data_i   (frt_data),
    .out_valid_o (mac_valid),
    .out_ready_i (mac_ready),
    .out_data_o  (mac_data)
  );

  msp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mac_valid),
    .in_ready_o  (mac_ready),
    .in_data_i   (mac_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  always_comb begin
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] nq;
    for (int l = 0; l < 3; l++) begin
      q  = div_data.quo[l];
      nq = ~q + Q_W'(1);
      if (div_data.neg[l]) begin
        lane_sat[l] = div_data.ovf[l] | q[Q_W-1] | (q[W-1] & (|q[W-2:0]));
        res[l]      = lane_sat[l] ? W_MIN : nq[W-1:0];
      end else begin
        lane_sat[l] = div_data.ovf[l] | (|q[Q_W-1:W-1]);
        res[l]      = lane_sat[l] ? W_MAX : q[W-1:0];
      end
    end
    out_d.result_x  = res[0];
    out_d.result_y  = res[1];
    out_d.result_z  = res[2];
    out_d.saturated = |lane_sat;
  end

  assign div_ready = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output drains");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && div_ready) |=> out_valid_o)
    else $error("divider word lost at output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      (out_data_o.result_x == W_MAX || out_data_o.result_x == W_MIN ||
       out_data_o.result_y == W_MAX || out_data_o.result_y == W_MIN ||
       out_data_o.result_z == W_MAX || out_data_o.result_z == W_MIN))
    else $error("saturated flag without clamped component");

endmodule
